[src/pad_pkg.sv]
`default_nettype none

package pad_pkg;

  localparam int COORD_BITS_DEF      = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 7;
  localparam int CORDIC_STEPS_DEF    = 16;

  // number of arctangent entries available
  localparam int TABLE_LEN = 24;
  // working width of x and y: 40-bit scaled magnitude plus gain and sign headroom
  localparam int DATA_W    = 43;
  localparam int GUARD_POS = 40;
  // binary angle, full turn is 2^32
  localparam int Z_W       = 32;
  localparam int ANGLE_W   = 16;

  typedef struct packed {
    logic               bypass;
    logic               origin;
    logic [ANGLE_W-1:0] fixed_deg;
  } side_t;

  // atan(2^-i) in binary angle units, rounded to nearest
  function automatic logic [Z_W-1:0] atan_entry(input logic [4:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[src/polar_angle_degrees_core.sv]
`default_nettype none

// Polar angle of a signed point (x_coord, y_coord) in degrees, counter-clockwise
// from the positive x axis, range [0, 360), with ANGLE_FRAC_BITS fraction bits.
// One point is taken per cycle through CORDIC_STEPS + 3 register stages: one
// input stage that folds the left half plane and catches the axes, one stage
// per CORDIC iteration, one multiply stage that scales the binary angle to
// degrees and one rounding stage that is also the output register. The input
// stage loads at the transfer in. Points on an axis give exact multiples of 90
// degrees; the origin sets is_origin with angle_deg at 0. While a result waits
// with out_ready low the whole pipeline holds and in_ready drops with it.
module polar_angle_degrees_core #(
  parameter int COORD_BITS      = pad_pkg::COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = pad_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = pad_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_BITS-1:0]  x_coord,
  input  wire logic signed [COORD_BITS-1:0]  y_coord,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pad_pkg::ANGLE_W-1:0]        angle_deg,
  output logic                               is_origin
);

  localparam int DW    = pad_pkg::DATA_W;
  localparam int GUARD = pad_pkg::GUARD_POS - COORD_BITS;
  localparam int NST   = (CORDIC_STEPS < pad_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                            : pad_pkg::TABLE_LEN;
  localparam logic [pad_pkg::ANGLE_W-1:0] DEG90  =
    pad_pkg::ANGLE_W'(90 << ANGLE_FRAC_BITS);
  localparam logic [pad_pkg::ANGLE_W-1:0] DEG180 =
    pad_pkg::ANGLE_W'(180 << ANGLE_FRAC_BITS);
  localparam logic [pad_pkg::ANGLE_W-1:0] DEG270 =
    pad_pkg::ANGLE_W'(270 << ANGLE_FRAC_BITS);
  localparam logic [pad_pkg::Z_W-1:0] HALF_TURN = pad_pkg::Z_W'(1) << (pad_pkg::Z_W - 1);

  logic en;

  logic signed [DW-1:0]           xe;
  logic signed [DW-1:0]           ye;
  logic signed [DW-1:0]           x_fold;
  logic signed [DW-1:0]           y_fold;
  logic [pad_pkg::Z_W-1:0]        z_fold;
  pad_pkg::side_t                 side_next;

  logic                           valid_pipe [0:NST];
  logic signed [DW-1:0]           x_pipe     [0:NST];
  logic signed [DW-1:0]           y_pipe     [0:NST];
  logic [pad_pkg::Z_W-1:0]        z_pipe     [0:NST];
  pad_pkg::side_t                 side_pipe  [0:NST];

  // advance everything when the output register is free or being drained
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    xe = {{(DW - COORD_BITS){x_coord[COORD_BITS-1]}}, x_coord};
    ye = {{(DW - COORD_BITS){y_coord[COORD_BITS-1]}}, y_coord};
    side_next.origin    = (x_coord == '0) && (y_coord == '0);
    side_next.bypass    = (x_coord == '0) || (y_coord == '0);
    side_next.fixed_deg = '0;
    if (x_coord == '0) begin
      if (y_coord[COORD_BITS-1]) begin
        side_next.fixed_deg = DEG270;
      end else if (y_coord != '0) begin
        side_next.fixed_deg = DEG90;
      end
    end else if (y_coord == '0) begin
      if (x_coord[COORD_BITS-1]) begin
        side_next.fixed_deg = DEG180;
      end
    end
    // rotate the left half plane by a half turn
    if (x_coord[COORD_BITS-1]) begin
      x_fold = (-xe) <<< GUARD;
      y_fold = (-ye) <<< GUARD;
      z_fold = HALF_TURN;
    end else begin
      x_fold = xe <<< GUARD;
      y_fold = ye <<< GUARD;
      z_fold = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe[0] <= 1'b0;
    end else if (en) begin
      valid_pipe[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_pipe[0]    <= x_fold;
      y_pipe[0]    <= y_fold;
      z_pipe[0]    <= z_fold;
      side_pipe[0] <= side_next;
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_step
    pad_cordic_stage #(
      .STEP(i)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (valid_pipe[i]),
      .x_in     (x_pipe[i]),
      .y_in     (y_pipe[i]),
      .z_in     (z_pipe[i]),
      .side_in  (side_pipe[i]),
      .valid_out(valid_pipe[i+1]),
      .x_out    (x_pipe[i+1]),
      .y_out    (y_pipe[i+1]),
      .z_out    (z_pipe[i+1]),
      .side_out (side_pipe[i+1])
    );
  end

  pad_deg_conv #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_deg (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (valid_pipe[NST]),
    .z_in      (z_pipe[NST]),
    .side_in   (side_pipe[NST]),
    .valid_out (out_valid),
    .angle_out (angle_deg),
    .origin_out(is_origin)
  );

endmodule

`default_nettype wire

[src/pad_cordic_stage.sv]
`default_nettype none

module pad_cordic_stage #(
  parameter int STEP = 0
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              valid_in,
  input  wire logic signed [pad_pkg::DATA_W-1:0] x_in,
  input  wire logic signed [pad_pkg::DATA_W-1:0] y_in,
  input  wire logic        [pad_pkg::Z_W-1:0]    z_in,
  input  wire pad_pkg::side_t                    side_in,
  output logic                                   valid_out,
  output logic signed      [pad_pkg::DATA_W-1:0] x_out,
  output logic signed      [pad_pkg::DATA_W-1:0] y_out,
  output logic             [pad_pkg::Z_W-1:0]    z_out,
  output pad_pkg::side_t                         side_out
);

  localparam logic [pad_pkg::Z_W-1:0] ANG = pad_pkg::atan_entry(5'(STEP));

  logic signed [pad_pkg::DATA_W-1:0] xs;
  logic signed [pad_pkg::DATA_W-1:0] ys;
  logic signed [pad_pkg::DATA_W-1:0] x_next;
  logic signed [pad_pkg::DATA_W-1:0] y_next;
  logic        [pad_pkg::Z_W-1:0]    z_next;
  logic                              y_pos;

  always_comb begin
    xs    = x_in >>> STEP;
    ys    = y_in >>> STEP;
    y_pos = !y_in[pad_pkg::DATA_W-1] && (y_in != '0);
    if (y_pos) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ANG;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

[src/pad_deg_conv.sv]
`default_nettype none

module pad_deg_conv #(
  parameter int ANGLE_FRAC_BITS = pad_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           valid_in,
  input  wire logic [pad_pkg::Z_W-1:0]        z_in,
  input  wire pad_pkg::side_t                 side_in,
  output logic                                valid_out,
  output logic      [pad_pkg::ANGLE_W-1:0]    angle_out,
  output logic                                origin_out
);

  localparam int DF_W   = 9 + ANGLE_FRAC_BITS;
  localparam int PROD_W = pad_pkg::Z_W + DF_W;
  localparam logic [DF_W-1:0]   DEG_FULL = DF_W'(360 << ANGLE_FRAC_BITS);
  localparam logic [PROD_W-1:0] HALF     = PROD_W'(1) << (pad_pkg::Z_W - 1);

  logic                  valid_mul;
  logic [PROD_W-1:0]     prod;
  pad_pkg::side_t        side_mul;
  logic [PROD_W-1:0]     sum;
  logic [DF_W-1:0]       d_round;
  logic [DF_W-1:0]       d_wrap;
  logic [pad_pkg::ANGLE_W-1:0] angle_next;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_mul <= 1'b0;
    end else if (en) begin
      valid_mul <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= PROD_W'(z_in) * PROD_W'(DEG_FULL);
      side_mul <= side_in;
    end
  end

  // round half up, wrap a full turn to zero, and use the fixed angle for axis points
  always_comb begin
    sum     = prod + HALF;
    d_round = sum[PROD_W-1:pad_pkg::Z_W];
    d_wrap  = (d_round >= DEG_FULL) ? d_round - DEG_FULL : d_round;
    if (side_mul.bypass) begin
      angle_next = side_mul.fixed_deg;
    end else begin
      angle_next = pad_pkg::ANGLE_W'(d_wrap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_out  <= angle_next;
      origin_out <= side_mul.origin;
    end
  end

endmodule

`default_nettype wire

[bench/polar_angle_degrees_core_test.sv]
`default_nettype none

module polar_angle_degrees_core_test;

  localparam int COORD_BITS      = pad_pkg::COORD_BITS_DEF;
  localparam int ANGLE_FRAC_BITS = pad_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int CORDIC_STEPS    = pad_pkg::CORDIC_STEPS_DEF;
  localparam int ANGLE_W         = pad_pkg::ANGLE_W;
  localparam int GUARD_SHIFT     = pad_pkg::GUARD_POS - COORD_BITS;
  localparam int PIPE_DEPTH      = CORDIC_STEPS + 3;

  localparam longint unsigned DEG_FULL = 64'd360 << ANGLE_FRAC_BITS;
  localparam logic [ANGLE_W-1:0] DEG_0   = '0;
  localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(270 << ANGLE_FRAC_BITS);

  localparam int NUM_DIRECTED    = 22;
  localparam int RANDOM_PER_PASS = 276;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int CYCLE_LIMIT     = 200000;

  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] C_ONE = COORD_BITS'(1);
  localparam logic signed [COORD_BITS-1:0] C_NEG = COORD_BITS'(-1);
  localparam logic signed [COORD_BITS-1:0] C_ZERO = COORD_BITS'(0);

  // atan(2^-i), full turn = 2^32
  localparam logic [31:0] ARCTAN_STEP [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               origin;
  } polar_result_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         known;
    logic [ANGLE_W-1:0]           angle;
    logic                         origin;
  } directed_point_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic                         out_valid;
  logic                         out_ready;
  logic [ANGLE_W-1:0]           angle_deg;
  logic                         is_origin;

  polar_result_t   pending_angles[$];
  directed_point_t directed_points [0:NUM_DIRECTED-1];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  points_sent    = 0;
  int  angles_checked = 0;
  int  send_idle_pct  = 7;
  int  recv_idle_pct  = 71;
  bit  hold_off_req   = 1'b0;

  polar_angle_degrees_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle_deg (angle_deg),
    .is_origin (is_origin)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CORDIC vectoring in 64-bit integers, then scale the binary angle to degrees
  function automatic polar_result_t polar_angle(input logic signed [COORD_BITS-1:0] px,
                                                input logic signed [COORD_BITS-1:0] py);
    longint          xa;
    longint          ya;
    longint          xs;
    longint          ys;
    logic [31:0]     z;
    longint unsigned zl;
    longint unsigned d;
    polar_result_t   r;
    xa = px;
    ya = py;
    z = '0;
    r.origin = 1'b0;
    r.angle = DEG_0;
    if (xa == 0 && ya == 0) begin
      r.origin = 1'b1;
    end else if (xa == 0) begin
      r.angle = (ya > 0) ? DEG_90 : DEG_270;
    end else if (ya == 0) begin
      r.angle = (xa > 0) ? DEG_0 : DEG_180;
    end else begin
      // fold the left half plane onto the right one
      if (xa < 0) begin
        xa = -xa;
        ya = -ya;
        z = 32'h8000_0000;
      end
      xa = xa <<< GUARD_SHIFT;
      ya = ya <<< GUARD_SHIFT;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        xs = xa >>> i;
        ys = ya >>> i;
        if (ya > 0) begin
          xa = xa + ys;
          ya = ya - xs;
          z = z + ARCTAN_STEP[i];
        end else begin
          xa = xa - ys;
          ya = ya + xs;
          z = z - ARCTAN_STEP[i];
        end
      end
      zl = z;
      d = (zl * DEG_FULL + (64'd1 << 31)) >> 32;
      if (d >= DEG_FULL) d = d - DEG_FULL;
      r.angle = d[ANGLE_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d, cycle %0d)",
             what, got, want, angles_checked, cycle_count);
    mismatch_count++;
  endtask

  // offer one point, hold it until the transfer, then queue its angle
  task automatic send_point(input logic signed [COORD_BITS-1:0] px,
                            input logic signed [COORD_BITS-1:0] py,
                            input polar_result_t want);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_coord  <= px;
    y_coord  <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_angles.push_back(want);
    points_sent++;
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_extreme();
    case ($urandom_range(4))
      0:       return C_MIN;
      1:       return C_NEG;
      2:       return C_ZERO;
      3:       return C_ONE;
      default: return C_MAX;
    endcase
  endfunction

  task automatic send_random_point();
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    px = COORD_BITS'($urandom);
    py = COORD_BITS'($urandom);
    case ($urandom_range(9))
      4: begin
        px = COORD_BITS'(int'($urandom_range(8)) - 4);
        py = COORD_BITS'(int'($urandom_range(8)) - 4);
      end
      5: begin
        if ($urandom_range(1)) px = C_ZERO;
        else py = C_ZERO;
      end
      6: begin
        px = pick_extreme();
        py = pick_extreme();
      end
      7: begin
        if ($urandom_range(1)) px = COORD_BITS'(int'($urandom_range(4)) - 2);
        else py = COORD_BITS'(int'($urandom_range(4)) - 2);
      end
      default: ;
    endcase
    send_point(px, py, polar_angle(px, py));
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_cycles;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_off_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    polar_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d angles still due", cycle_count,
               pending_angles.size());
      $display("Some tests failed");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected transfer, angle", angle_deg, 0);
      end else begin
        want = pending_angles.pop_front();
        if (angle_deg !== want.angle) report_mismatch("angle_deg", angle_deg, want.angle);
        if (is_origin !== want.origin) report_mismatch("is_origin", is_origin, want.origin);
      end
      angles_checked++;
    end
  end

  initial begin
    polar_result_t want;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    x_coord  <= '0;
    y_coord  <= '0;
    directed_points = '{
      '{C_ZERO, C_ZERO, 1'b1, DEG_0,   1'b1},
      '{C_ZERO, C_ONE,  1'b1, DEG_90,  1'b0},
      '{C_ZERO, C_NEG,  1'b1, DEG_270, 1'b0},
      '{C_ONE,  C_ZERO, 1'b1, DEG_0,   1'b0},
      '{C_NEG,  C_ZERO, 1'b1, DEG_180, 1'b0},
      '{C_MAX,  C_ZERO, 1'b1, DEG_0,   1'b0},
      '{C_MIN,  C_ZERO, 1'b1, DEG_180, 1'b0},
      '{C_ZERO, C_MAX,  1'b1, DEG_90,  1'b0},
      '{C_ZERO, C_MIN,  1'b1, DEG_270, 1'b0},
      '{C_MAX,  C_MAX,  1'b0, DEG_0,   1'b0},
      '{C_MIN,  C_MIN,  1'b0, DEG_0,   1'b0},
      '{C_MIN,  C_MAX,  1'b0, DEG_0,   1'b0},
      '{C_MAX,  C_MIN,  1'b0, DEG_0,   1'b0},
      '{C_ONE,  C_ONE,  1'b0, DEG_0,   1'b0},
      '{C_NEG,  C_NEG,  1'b0, DEG_0,   1'b0},
      '{C_ONE,  C_NEG,  1'b0, DEG_0,   1'b0},
      '{C_NEG,  C_ONE,  1'b0, DEG_0,   1'b0},
      '{C_MAX,  C_NEG,  1'b0, DEG_0,   1'b0},
      '{C_MAX,  C_ONE,  1'b0, DEG_0,   1'b0},
      '{C_MIN,  C_NEG,  1'b0, DEG_0,   1'b0},
      '{C_MIN,  C_ONE,  1'b0, DEG_0,   1'b0},
      '{C_ONE,  C_MIN,  1'b0, DEG_0,   1'b0}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_points[i].known) begin
        want.angle  = directed_points[i].angle;
        want.origin = directed_points[i].origin;
      end else begin
        want = polar_angle(directed_points[i].x, directed_points[i].y);
      end
      send_point(directed_points[i].x, directed_points[i].y, want);
    end

    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PASS; n++) begin
        // back up the pipeline while points keep coming
        if (pass == 2 && n == 60) hold_off_req = 1'b1;
        send_random_point();
      end
      if (pass == 0) begin
        // drop valid and let every angle come out before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_angles.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);

    $display("Sent %0d points: origin, axes and extreme coordinates, then random quadrants",
             points_sent);
    $display("Checked %0d angles under three stall patterns and one long output hold-off",
             angles_checked);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[polar_angle_degrees_core.f]
src/pad_pkg.sv
src/pad_cordic_stage.sv
src/pad_deg_conv.sv
src/polar_angle_degrees_core.sv
bench/polar_angle_degrees_core_test.sv
